// File: design/cheb_pkg.sv
// ----------------------------------------------------------------------------
// cheb_pkg
// Shared widths, limits and codes for the Chebyshev polynomial evaluator.
// ----------------------------------------------------------------------------
package cheb_pkg;

  // word field widths
  localparam int ARG_W = 32;
  localparam int DEG_W = 6;
  localparam int VAL_W = 38;

  // saturation bound of every recurrence value: +-2^OUT_LIM_LOG2
  localparam int    OUT_LIM_LOG2 = 36;
  localparam longint OUT_LIM     = 64'sd1 <<< OUT_LIM_LOG2;

  // low slice of the recurrence value fed to the multiplier in the first pass
  localparam int SPLIT_W = 19;

  // parameter defaults
  localparam int MAX_DEGREE_DEF = 63;
  localparam int FRAC_BITS_DEF  = 30;

  // polynomial kind codes
  localparam logic KIND_T = 1'b0;
  localparam logic KIND_U = 1'b1;

endpackage

// File: design/chebyshev_polynomial_eval_unit.sv
// ----------------------------------------------------------------------------
// chebyshev_polynomial_eval_unit
// Evaluates T_n(x) or U_n(x) by the three-term recurrence on one shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Degrees 0 and 1 finish
// at once: the result strobes on out_valid in the cycle after the accepting
// edge. A degree n of 2 or more (clamped to MAX_DEGREE) runs n-1 recurrence
// steps, each through S_MUL_LO, S_MUL_HI and S_UPD, and the result strobes as
// the last step's S_UPD completes. Each step needs all of these states because
// one 32x20 multiplier forms the 32x38 product in two passes (low slice, then
// high slice) before the combine/subtract/saturate cycle. busy drops in the
// cycle that carries the result, so a new word may be started alongside it.
// The result is valid for exactly that one cycle; the receiver cannot stall
// it, so it must capture out_value whenever out_valid is high.
// ----------------------------------------------------------------------------
module chebyshev_polynomial_eval_unit #(
  parameter int MAX_DEGREE = cheb_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = cheb_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [cheb_pkg::ARG_W-1:0]  in_arg_x,
  input  logic        [cheb_pkg::DEG_W-1:0]  in_degree,
  input  logic                               in_opcode,
  output logic                               out_valid,
  output logic signed [cheb_pkg::VAL_W-1:0]  out_value
);

  import cheb_pkg::*;

  // degree counter: wide enough for MAX_DEGREE and for the degree field
  localparam int CNT_W = $clog2(MAX_DEGREE + 1);
  localparam int CMP_W = (CNT_W > DEG_W) ? CNT_W : DEG_W;

  // multiplier operand and product widths
  localparam int MUL_B_W = VAL_W - SPLIT_W + 1;   // signed high slice / zero-ext low slice
  localparam int MUL_W   = ARG_W + MUL_B_W;
  localparam int PROD_W  = ARG_W + VAL_W;         // full x * p
  localparam int DIFF_W  = PROD_W + 1;

  // 2x*p / 2^FRAC_BITS == x*p / 2^(FRAC_BITS-1)
  localparam int SHIFT = FRAC_BITS - 1;

  // seed P0 = 1.0, saturated when 1.0 lies beyond the bound
  localparam logic signed [VAL_W-1:0] ONE_VAL =
    (FRAC_BITS > OUT_LIM_LOG2) ? VAL_W'(OUT_LIM) : VAL_W'(64'sd1 <<< FRAC_BITS);

  localparam logic signed [DIFF_W-1:0] LIM_POS = DIFF_W'(OUT_LIM);
  localparam logic signed [DIFF_W-1:0] LIM_NEG = -DIFF_W'(OUT_LIM);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL_LO,   // x * low slice of P(k)
    S_MUL_HI,   // x * high slice of P(k)
    S_UPD       // combine, shift, subtract P(k-1), saturate
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [ARG_W-1:0]   x_r, x_nxt;
  logic signed [VAL_W-1:0]   prev_r, prev_nxt;
  logic signed [VAL_W-1:0]   cur_r, cur_nxt;
  logic        [CMP_W-1:0]   rem_r, rem_nxt;
  logic signed [MUL_W-1:0]   plo_r, plo_nxt;
  logic signed [MUL_W-1:0]   phi_r, phi_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0]   out_value_r, out_value_nxt;

  logic                      accept;
  logic        [CMP_W-1:0]   deg_ext;
  logic        [CMP_W-1:0]   n_eff;
  logic signed [VAL_W-1:0]   seed1;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [VAL_W-1:0]   step_val;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // degree clamp
  assign deg_ext = CMP_W'(in_degree);
  assign n_eff   = (deg_ext > CMP_W'(MAX_DEGREE)) ? CMP_W'(MAX_DEGREE) : deg_ext;

  // P1 = x for T, 2x for U; |2x| <= 2^32 stays inside the bound
  assign seed1 = (in_opcode == KIND_U) ? (VAL_W'(in_arg_x) <<< 1) : VAL_W'(in_arg_x);

  // shared multiplier: low pass uses the unsigned low slice, high pass the signed rest
  assign mul_b = (state_r == S_MUL_LO) ? $signed({1'b0, cur_r[SPLIT_W-1:0]})
                                       : $signed({cur_r[VAL_W-1], cur_r[VAL_W-1:SPLIT_W]});
  assign mul_p = x_r * mul_b;

  // floor(x*p / 2^(FRAC_BITS-1)) - P(k-1), saturated
  assign prod     = (PROD_W'(phi_r) <<< SPLIT_W) + PROD_W'(plo_r);
  assign prod_sh  = prod >>> SHIFT;
  assign diff     = DIFF_W'(prod_sh) - DIFF_W'(prev_r);
  assign step_val = (diff > LIM_POS) ? VAL_W'(LIM_POS) :
                    (diff < LIM_NEG) ? VAL_W'(LIM_NEG) : VAL_W'(diff);

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    rem_nxt       = rem_r;
    plo_nxt       = plo_r;
    phi_nxt       = phi_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt    = in_arg_x;
          prev_nxt = ONE_VAL;
          cur_nxt  = seed1;
          rem_nxt  = n_eff - CMP_W'(1);
          if (n_eff == '0) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = ONE_VAL;
          end else if (n_eff == CMP_W'(1)) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = seed1;
          end else begin
            state_nxt = S_MUL_LO;
          end
        end
      end
      S_MUL_LO: begin
        plo_nxt   = mul_p;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        phi_nxt   = mul_p;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        prev_nxt = cur_r;
        cur_nxt  = step_val;
        rem_nxt  = rem_r - CMP_W'(1);
        if (rem_r == CMP_W'(1)) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = step_val;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_MUL_LO;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // datapath: no reset needed
    x_r         <= x_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    rem_r       <= rem_nxt;
    plo_r       <= plo_nxt;
    phi_r       <= phi_nxt;
    out_value_r <= out_value_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule
